FILE: rtl/core/bs_pkg.sv
// Shared types and constants of the bitonic sorter.
package bs_pkg;

    // Element word.
    localparam int W_VALUE = 32;
    typedef logic signed [W_VALUE-1:0] t_value;

    // Job size exponent register.
    localparam int W_LOG = 3;
    localparam logic [W_LOG-1:0] LOG_RESET = 3'd6;

    // Default capacity of the element store.
    localparam int MAX_ELEMENTS_DEF = 64;

    // Sort direction of a compare-exchange.
    localparam logic ASCENDING  = 1'b1;
    localparam logic DESCENDING = 1'b0;

    // Row width of one store bank for a given element address width.
    function automatic int f_row_width(input int addr_w);
        return (addr_w > 1) ? addr_w - 1 : 1;
    endfunction

endpackage

FILE: rtl/core/bs_bank.sv
// One bank of the element store: one write port, one registered read port.
module bs_bank #(
    parameter int ADDR_W = 5
) (
    input  logic                i_clk,
    input  logic                i_wr_en,
    input  logic [ADDR_W-1:0]   i_wr_addr,
    input  bs_pkg::t_value      i_wr_data,
    input  logic [ADDR_W-1:0]   i_rd_addr,
    output bs_pkg::t_value      o_rd_data
);
    import bs_pkg::*;

    localparam int DEPTH = 2 ** ADDR_W;

    t_value r_mem [DEPTH];
    t_value r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read-first: a read and a write to the same row in one cycle return the old word.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/bitonic_sorter_unit.sv
// Top level of the bitonic sorter: load, compare-exchange sequencer, emit.
//
//  channel   direction  handshake                   payload
//  --------  ---------  --------------------------  --------------------------------
//  input     in         i_valid / o_ready           i_value
//  result    out        o_valid / i_ready           o_sorted_value, o_last
//  config    in         i_cfg_valid / o_cfg_ready   i_cfg_log_count
//
// A job of n = 2^e words (e = log_count, capped so n fits the store) is loaded at one
// word per cycle. One comparator then runs the bitonic network: e*(e+1)/2 passes, each
// running its n/2 compare-exchanges and then flushing the last write back. The store is
// split into two banks by address parity, so both operands of a pair are read and
// written in one cycle. Each result word then goes through read, capture and hand off,
// the last held for any stall on i_ready. Reset is synchronous and active low; it sets
// log_count to 6 and empties the job. The store itself is not cleared. o_ready is high
// only while loading; config is always taken.
module bitonic_sorter_unit #(
    parameter int MAX_ELEMENTS = bs_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // element input
    input  logic                       i_valid,
    output logic                       o_ready,
    input  bs_pkg::t_value             i_value,
    // sorted output
    output logic                       o_valid,
    input  logic                       i_ready,
    output bs_pkg::t_value             o_sorted_value,
    output logic                       o_last,
    // configuration
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [bs_pkg::W_LOG-1:0]   i_cfg_log_count
);
    import bs_pkg::*;

    // Element address width, bank row width, largest exponent that fits the store.
    localparam int AW      = $clog2(MAX_ELEMENTS);
    localparam int BW      = f_row_width(AW);
    localparam int LOG_MAX = $clog2(MAX_ELEMENTS + 1) - 1;

    // Sequencer states.
    localparam logic [2:0] S_LOAD      = 3'd0;
    localparam logic [2:0] S_SORT      = 3'd1;
    localparam logic [2:0] S_DRAIN     = 3'd2;
    localparam logic [2:0] S_EMIT_RD   = 3'd3;
    localparam logic [2:0] S_EMIT_WAIT = 3'd4;
    localparam logic [2:0] S_EMIT_HOLD = 3'd5;

    // Row of an element inside its bank: drop the lowest address bit.
    function automatic logic [BW-1:0] f_row(input logic [AW-1:0] addr);
        logic [AW-1:0] shifted;
        shifted = addr >> 1;
        return shifted[BW-1:0];
    endfunction

    // Control registers.
    logic [2:0]       r_state,    n_state;
    logic [W_LOG-1:0] r_log,      n_log;
    logic [AW-1:0]    r_load_cnt, n_load_cnt;
    logic [W_LOG-1:0] r_s,        n_s;        // block size exponent of the current stage
    logic [W_LOG-1:0] r_d,        n_d;        // distance exponent of the current pass
    logic [AW-1:0]    r_j,        n_j;        // pair index within the pass
    logic             r_to_emit,  n_to_emit;
    logic [AW-1:0]    r_emit_idx, n_emit_idx;
    logic             r_cx_valid;

    // Compare-exchange stage registers.
    logic             r_cx_ipar;
    logic             r_cx_asc;
    logic [BW-1:0]    r_cx_row0;
    logic [BW-1:0]    r_cx_row1;

    // Output register.
    t_value           r_out_data;
    logic             r_out_last;

    // Job size.
    logic [W_LOG-1:0] w_exp;
    logic [AW:0]      w_size;
    logic [AW:0]      w_size_m1;
    logic [AW-1:0]    w_last_idx;
    logic [AW-1:0]    w_last_pair;

    // Pair address generation.
    logic [AW:0]      w_dbit_ext;
    logic [AW-1:0]    w_dbit;
    logic [AW-1:0]    w_low_mask;
    logic [AW-1:0]    w_i;
    logic [AW-1:0]    w_p;
    logic [AW:0]      w_sbit;
    logic             w_asc;
    logic             w_ipar;

    // Bank ports.
    logic             w_wr_en0, w_wr_en1;
    logic [BW-1:0]    w_wr_addr0, w_wr_addr1;
    t_value           w_wr_data0, w_wr_data1;
    logic [BW-1:0]    w_rd_addr0, w_rd_addr1;
    t_value           w_rd_data0, w_rd_data1;

    // Comparator.
    t_value           w_x, w_y, w_lo, w_hi, w_i_val, w_p_val;
    logic             w_gt;

    logic             w_load_acc;
    logic             w_load_par;
    logic             w_out_acc;

    // ---------------------------------------------------------------- job size
    assign w_exp       = (r_log > W_LOG'(LOG_MAX)) ? W_LOG'(LOG_MAX) : r_log;
    assign w_size      = (AW + 1)'(1) << w_exp;
    assign w_size_m1   = w_size - (AW + 1)'(1);
    assign w_last_idx  = w_size_m1[AW-1:0];
    assign w_last_pair = w_last_idx >> 1;

    // ---------------------------------------------------------------- pair addresses
    // Insert a zero at bit d of the pair index to get the lower element; set it for the
    // partner. The lower element sorts ascending when bit s of its address is clear.
    assign w_dbit_ext = (AW + 1)'(1) << r_d;
    assign w_dbit     = w_dbit_ext[AW-1:0];
    assign w_low_mask = w_dbit - AW'(1);
    assign w_i        = ((r_j & ~w_low_mask) << 1) | (r_j & w_low_mask);
    assign w_p        = w_i | w_dbit;
    assign w_sbit     = (AW + 1)'(1) << r_s;
    assign w_asc      = (({1'b0, w_i} & w_sbit) == '0) ? ASCENDING : DESCENDING;
    assign w_ipar     = ^w_i;

    // ---------------------------------------------------------------- handshakes
    assign o_ready     = (r_state == S_LOAD);
    assign o_cfg_ready = 1'b1;
    assign w_load_acc  = i_valid && o_ready;
    assign w_load_par  = ^r_load_cnt;
    assign o_valid     = (r_state == S_EMIT_HOLD);
    assign w_out_acc   = o_valid && i_ready;

    // ---------------------------------------------------------------- comparator
    // Operands come back from the banks' registered reads in the cycle after issue; put the lower element in x.
    assign w_x     = r_cx_ipar ? w_rd_data1 : w_rd_data0;
    assign w_y     = r_cx_ipar ? w_rd_data0 : w_rd_data1;
    assign w_gt    = (w_x > w_y);
    assign w_lo    = w_gt ? w_y : w_x;
    assign w_hi    = w_gt ? w_x : w_y;
    assign w_i_val = (r_cx_asc == ASCENDING) ? w_lo : w_hi;
    assign w_p_val = (r_cx_asc == ASCENDING) ? w_hi : w_lo;

    // ---------------------------------------------------------------- bank ports
    // Writes come either from loading or from the exchange stage, never both at once.
    always_comb begin
        if (r_cx_valid) begin
            w_wr_en0   = 1'b1;
            w_wr_en1   = 1'b1;
            w_wr_addr0 = r_cx_row0;
            w_wr_addr1 = r_cx_row1;
            w_wr_data0 = r_cx_ipar ? w_p_val : w_i_val;
            w_wr_data1 = r_cx_ipar ? w_i_val : w_p_val;
        end else begin
            w_wr_en0   = w_load_acc && !w_load_par;
            w_wr_en1   = w_load_acc && w_load_par;
            w_wr_addr0 = f_row(r_load_cnt);
            w_wr_addr1 = f_row(r_load_cnt);
            w_wr_data0 = i_value;
            w_wr_data1 = i_value;
        end
    end

    // Issue the pair while sorting; otherwise point both banks at the next result word.
    always_comb begin
        if (r_state == S_SORT) begin
            w_rd_addr0 = w_ipar ? f_row(w_p) : f_row(w_i);
            w_rd_addr1 = w_ipar ? f_row(w_i) : f_row(w_p);
        end else begin
            w_rd_addr0 = f_row(r_emit_idx);
            w_rd_addr1 = f_row(r_emit_idx);
        end
    end

    bs_bank #(
        .ADDR_W (BW)
    ) u_bank0 (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en0),
        .i_wr_addr (w_wr_addr0),
        .i_wr_data (w_wr_data0),
        .i_rd_addr (w_rd_addr0),
        .o_rd_data (w_rd_data0)
    );

    bs_bank #(
        .ADDR_W (BW)
    ) u_bank1 (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en1),
        .i_wr_addr (w_wr_addr1),
        .i_wr_data (w_wr_data1),
        .i_rd_addr (w_rd_addr1),
        .o_rd_data (w_rd_data1)
    );

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state    = r_state;
        n_log      = r_log;
        n_load_cnt = r_load_cnt;
        n_s        = r_s;
        n_d        = r_d;
        n_j        = r_j;
        n_to_emit  = r_to_emit;
        n_emit_idx = r_emit_idx;

        unique case (r_state)
            S_LOAD: begin
                if (w_load_acc) begin
                    if (r_load_cnt == w_last_idx) begin
                        // Job complete: sort it, or hand a single word straight out.
                        n_load_cnt = '0;
                        n_emit_idx = '0;
                        n_s        = W_LOG'(1);
                        n_d        = '0;
                        n_j        = '0;
                        n_to_emit  = 1'b0;
                        n_state    = (w_exp == '0) ? S_EMIT_RD : S_SORT;
                    end else begin
                        n_load_cnt = r_load_cnt + AW'(1);
                    end
                end
            end
            S_SORT: begin
                if (r_j == w_last_pair) begin
                    // Last pair of the pass: step to the next pass and flush the write.
                    n_j     = '0;
                    n_state = S_DRAIN;
                    if (r_d == '0) begin
                        if (r_s == w_exp) begin
                            n_to_emit = 1'b1;
                        end else begin
                            n_s = r_s + W_LOG'(1);
                            n_d = r_s;
                        end
                    end else begin
                        n_d = r_d - W_LOG'(1);
                    end
                end else begin
                    n_j = r_j + AW'(1);
                end
            end
            S_DRAIN: begin
                n_state = r_to_emit ? S_EMIT_RD : S_SORT;
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_WAIT;
            end
            S_EMIT_WAIT: begin
                n_state = S_EMIT_HOLD;
            end
            S_EMIT_HOLD: begin
                if (w_out_acc) begin
                    if (r_out_last) begin
                        n_state = S_LOAD;
                    end else begin
                        n_emit_idx = r_emit_idx + AW'(1);
                        n_state    = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase

        // A config write drops any partly loaded job.
        if (i_cfg_valid && o_cfg_ready) begin
            n_log      = i_cfg_log_count;
            n_load_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_log      <= LOG_RESET;
            r_load_cnt <= '0;
            r_s        <= '0;
            r_d        <= '0;
            r_j        <= '0;
            r_to_emit  <= 1'b0;
            r_emit_idx <= '0;
            r_cx_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_log      <= n_log;
            r_load_cnt <= n_load_cnt;
            r_s        <= n_s;
            r_d        <= n_d;
            r_j        <= n_j;
            r_to_emit  <= n_to_emit;
            r_emit_idx <= n_emit_idx;
            r_cx_valid <= (r_state == S_SORT);
        end
    end

    // Hold the issued pair's bank rows and direction for the exchange cycle.
    always_ff @(posedge i_clk) begin
        r_cx_ipar <= w_ipar;
        r_cx_asc  <= w_asc;
        r_cx_row0 <= w_rd_addr0;
        r_cx_row1 <= w_rd_addr1;
    end

    // Capture the result word once the bank read returns.
    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT_WAIT) begin
            r_out_data <= (^r_emit_idx) ? w_rd_data1 : w_rd_data0;
            r_out_last <= (r_emit_idx == w_last_idx);
        end
    end

    assign o_sorted_value = r_out_data;
    assign o_last         = r_out_last;

    // ---------------------------------------------------------------- checks
    // Exchange writes occur only in the cycle after a pair was issued.
    a_cx_in_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cx_valid |-> (r_state == S_SORT || r_state == S_DRAIN))
        else $error("exchange write outside sorting");

    // The two elements of a pair always live in opposite banks.
    a_pair_banks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SORT) |-> ((^w_i) != (^w_p)))
        else $error("pair elements share a bank");

    // No new word is taken while a result word is pending.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid)
        else $error("input accepted while output pending");

endmodule

FILE: verif/bitonic_sorter_unit_test.sv
// Self-checking testbench of bitonic_sorter_unit with its own sorting-network predictor.
module bitonic_sorter_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bs_pkg::*;

    // Store capacity handed to the block; the job size is capped at this.
    localparam int MAX_WORDS = MAX_ELEMENTS_DEF;
    // Stop sending once this many input words have gone in.
    localparam int TARGET_WORDS = 310;
    // Hard stop. The slowest legal run (every word behind a long sender gap, every
    // sorted word behind a long stall, a full sort per big job) stays far below
    // this.
    localparam int CYCLE_LIMIT = 400000;
    // Idle cycles after the last due word before a register write.
    localparam int SETTLE_CYCLES = 16;
    // Idle cycles at the very end to catch stray output words.
    localparam int END_CYCLES = 64;
    // Largest exponent the block honors; higher ones saturate to it.
    localparam logic [W_LOG-1:0] LOG_CAP = 3'd6;
    localparam logic [W_LOG-1:0] LOG_OVERSIZE = 3'd7;
    localparam int REPORT_LIMIT = 10;

    localparam t_value VALUE_MIN = t_value'(32'h8000_0000);
    localparam t_value VALUE_MAX = t_value'(32'h7fff_ffff);

    // Flavors of random element content.
    typedef enum int {
        MIX_WIDE,    // any 32-bit pattern
        MIX_NARROW,  // small band around zero, many duplicates
        MIX_EDGE,    // near the signed limits, or zero or minus one
        MIX_ANY      // pick one of the above per word
    } t_value_mix;

    // One sorted word as the block should hand it out.
    typedef struct packed {
        t_value value;
        logic   last;
    } t_sorted_word;

    // ------------------------------------------------------------------
    // DUT signals; every input holds a known value from time zero.
    // ------------------------------------------------------------------
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    t_value             i_value = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    t_value             o_sorted_value;
    logic               o_last;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [W_LOG-1:0]   i_cfg_log_count = '0;

    bitonic_sorter_unit #(
        .MAX_ELEMENTS(MAX_WORDS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_sorted_value (o_sorted_value),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_log_count(i_cfg_log_count)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the job store, fill level and exponent.
    // ------------------------------------------------------------------
    t_value             job_words [MAX_WORDS];
    int unsigned        words_loaded = 0;
    logic [W_LOG-1:0]   log_count_model = LOG_RESET;
    t_sorted_word       sorted_words_due [$];

    int unsigned        words_sent = 0;
    int unsigned        mismatches = 0;
    int unsigned        cycle_count = 0;
    int                 stall_left = 0;
    bit                 src_quiet = 1'b0;
    bit                 sink_quiet = 1'b0;

    // Job size from the exponent: saturate at the cap, then halve until it fits.
    function automatic int unsigned job_length();
        int unsigned e;
        int unsigned n;
        e = (log_count_model > LOG_CAP) ? LOG_CAP : log_count_model;
        n = 1 << e;
        while (n > 1 && n > MAX_WORDS) n >>= 1;
        return n;
    endfunction

    // Run the bitonic network over the first n stored words: blocks of growing size,
    // lower halves ascending and upper halves descending, merged at halving distances.
    function automatic void sort_job_words(input int unsigned n);
        int unsigned blk;
        int unsigned stride;
        int unsigned i;
        int unsigned j;
        logic        gt;
        logic        dir;
        t_value      tmp;
        for (blk = 2; blk <= n; blk <<= 1) begin
            for (stride = blk >> 1; stride > 0; stride >>= 1) begin
                for (i = 0; i < n; i++) begin
                    j = i ^ stride;
                    if (j > i) begin
                        gt  = job_words[i] > job_words[j];
                        dir = ((i & blk) == 0) ? ASCENDING : DESCENDING;
                        if ((gt ? ASCENDING : DESCENDING) == dir) begin
                            tmp          = job_words[i];
                            job_words[i] = job_words[j];
                            job_words[j] = tmp;
                        end
                    end
                end
            end
        end
    endfunction

    // Store one accepted word; when it closes the job, queue the whole sorted job.
    function automatic void load_word(input t_value v);
        int unsigned  n;
        t_sorted_word w;
        n = job_length();
        if (words_loaded >= n) words_loaded = 0;
        job_words[words_loaded] = v;
        words_loaded++;
        if (words_loaded == n) begin
            sort_job_words(n);
            for (int unsigned k = 0; k < n; k++) begin
                w.value = job_words[k];
                w.last  = (k + 1 == n);
                sorted_words_due.push_back(w);
            end
            words_loaded = 0;
        end
    endfunction

    function automatic void note_failure(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) $display("mismatch: %s", msg);
    endfunction

    // Idle length: mostly none or short, now and then long; none in a quiet stretch.
    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_value pick_value(input t_value_mix mix);
        t_value_mix sel;
        sel = (mix == MIX_ANY) ? t_value_mix'($urandom_range(0, 2)) : mix;
        case (sel)
            MIX_WIDE: begin
                return t_value'($urandom);
            end
            MIX_NARROW: begin
                return t_value'($urandom_range(0, 15)) - t_value'(8);
            end
            default: begin
                case ($urandom_range(0, 5))
                    0: return VALUE_MIN;
                    1: return VALUE_MAX;
                    2: return '0;
                    3: return '1;
                    4: return VALUE_MIN + t_value'($urandom_range(0, 3));
                    default: return VALUE_MAX - t_value'($urandom_range(0, 3));
                endcase
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result side: throttle ready, check every word that moves.
    // ------------------------------------------------------------------

    // Drop ready for random stretches unless the sink is in a quiet stretch.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left--;
        end else begin
            i_ready <= 1'b1;
            if (!sink_quiet && $urandom_range(0, 2) == 0) stall_left = pick_gap(1'b0);
        end
    end

    // Compare each handed-off word with the oldest one due, field by field.
    always @(posedge i_clk) begin : check_words
        t_sorted_word due;
        if (i_rst_n && o_valid && i_ready) begin
            if (sorted_words_due.size() == 0) begin
                note_failure($sformatf("unexpected word value %0d last %0b",
                                       o_sorted_value, o_last));
            end else begin
                due = sorted_words_due.pop_front();
                if (o_sorted_value !== due.value || o_last !== due.last) begin
                    note_failure($sformatf("value exp %0d got %0d, last exp %0b got %0b",
                                           due.value, o_sorted_value, due.last, o_last));
                end
            end
        end
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("bitonic_sorter_unit regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Present one word after a random gap and hold it until taken. Valid is only
    // lowered when a gap follows, so back-to-back words keep it high.
    task automatic send_word(input t_value v);
        int gap;
        gap = pick_gap(src_quiet);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        load_word(v);
        words_sent++;
    endtask

    // Write the exponent; the block drops any partly loaded job.
    task automatic write_log_count(input logic [W_LOG-1:0] e);
        i_cfg_valid     <= 1'b1;
        i_cfg_log_count <= e;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid     <= 1'b0;
        log_count_model = e;
        words_loaded    = 0;
    endtask

    // Hold the sender until every due word is out, then let the block settle.
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        while (sorted_words_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // No write yet: the reset exponent must give a full 64-word job.
    task automatic test_reset_size();
        repeat (MAX_WORDS) send_word(pick_value(MIX_ANY));
        wait_for_drain();
    endtask

    // Signed limits, zero and minus one, then duplicated limits in a larger job.
    task automatic test_extreme_values();
        write_log_count(3'd2);
        send_word(VALUE_MAX);
        send_word(VALUE_MIN);
        send_word('1);
        send_word('0);
        wait_for_drain();
        write_log_count(3'd3);
        send_word(t_value'(1));
        send_word(VALUE_MAX);
        send_word(VALUE_MIN);
        send_word('0);
        send_word('1);
        send_word(VALUE_MIN);
        send_word(VALUE_MAX);
        send_word(t_value'(1));
        wait_for_drain();
    endtask

    // Exponent zero: every word comes straight back marked last.
    task automatic test_single_word_jobs();
        write_log_count(3'd0);
        send_word(VALUE_MIN);
        send_word(VALUE_MAX);
        send_word('0);
        wait_for_drain();
    endtask

    // Two-word jobs, one reversed and one already in order.
    task automatic test_pair_jobs();
        write_log_count(3'd1);
        send_word(VALUE_MAX);
        send_word(VALUE_MIN);
        send_word(VALUE_MIN);
        send_word(VALUE_MAX);
        wait_for_drain();
    endtask

    // Leave a job partly loaded, rewrite the exponent, and make sure the leftovers vanish.
    task automatic test_discarded_job();
        write_log_count(3'd3);
        send_word(VALUE_MAX);
        send_word(VALUE_MIN);
        send_word(t_value'(5));
        wait_for_drain();
        write_log_count(3'd2);
        send_word(t_value'(-3));
        send_word(t_value'(7));
        send_word(t_value'(-3));
        send_word('0);
        wait_for_drain();
    endtask

    // Phases of well-formed jobs with random content, mostly small, some broken jobs
    // left behind for the next write to drop. First phase saturates the exponent,
    // second uses zero.
    task automatic test_random_jobs();
        int               phase;
        int               r;
        int               jobs;
        int unsigned      n;
        logic [W_LOG-1:0] e;
        t_value_mix       mix;
        phase = 0;
        while (words_sent < TARGET_WORDS) begin
            if (phase == 0) begin
                e = LOG_OVERSIZE;
            end else if (phase == 1) begin
                e = 3'd0;
            end else begin
                r = $urandom_range(0, 19);
                if (r < 3)       e = 3'd0;
                else if (r < 7)  e = 3'd1;
                else if (r < 11) e = 3'd2;
                else if (r < 15) e = 3'd3;
                else if (r < 18) e = 3'd4;
                else if (r < 19) e = 3'd5;
                else             e = W_LOG'($urandom_range(6, 7));
            end
            write_log_count(e);
            n = job_length();
            // some phases run without any idling on one side or the other
            src_quiet  = ($urandom_range(0, 3) == 0);
            sink_quiet = ($urandom_range(0, 3) == 0);
            jobs = (n >= 32) ? 1 : $urandom_range(1, 3);
            repeat (jobs) begin
                mix = t_value_mix'($urandom_range(0, 3));
                repeat (n) send_word(pick_value(mix));
            end
            // broken job: the next exponent write must throw it away
            if (n > 1 && $urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, n - 1)) send_word(pick_value(MIX_ANY));
            end
            wait_for_drain();
            phase++;
        end
        src_quiet  = 1'b0;
        sink_quiet = 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_size();
        test_extreme_values();
        test_single_word_jobs();
        test_pair_jobs();
        test_discarded_job();
        test_random_jobs();

        // catch anything the block sends after the last due word
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && sorted_words_due.size() == 0) begin
            $display("bitonic_sorter_unit regression: pass");
        end else begin
            $display("bitonic_sorter_unit regression: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/bs_pkg.sv
rtl/core/bs_bank.sv
rtl/core/bitonic_sorter_unit.sv
verif/bitonic_sorter_unit_test.sv
